[rtl/core/afs_pkg.sv]
// Shared types and constants for the animation frame sequencer.
// No dependencies; imported by afs_divider and animation_frame_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package afs_pkg;

  // Width of the elapsed-time input field
  localparam int ElapsedBits = 16;

  // Width of the configuration register index
  localparam int CfgIdxBits = 3;

  // Pass length after reset, in milliseconds
  localparam int TotalReset = 1000;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_TOTAL_DURATION = 3'd0,
    CFG_FRAME_COUNT    = 3'd1,
    CFG_LOOP_KEYFRAME  = 3'd2,
    CFG_PLAY_BACKWARDS = 3'd3,
    CFG_PLAY_ONCE      = 3'd4,
    CFG_HOLD_PAUSED    = 3'd5
  } afs_cfg_idx_t;

  // Status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } afs_div_stat_t;

endpackage

`default_nettype wire

[rtl/core/afs_divider.sv]
// Shared restoring divider: one quotient bit per cycle, quotient and remainder.
// Depends on afs_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module afs_divider #(
  parameter int DIVIDEND_BITS = 33,
  parameter int DIVISOR_BITS  = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [DIVIDEND_BITS-1:0]          dividend,
  input  wire logic [DIVISOR_BITS-1:0]           divisor,
  output logic      [DIVIDEND_BITS-1:0]          quotient,
  output logic      [DIVISOR_BITS-1:0]           remainder,
  output afs_pkg::afs_div_stat_t                 stat
);
  import afs_pkg::*;

  localparam int CntBits = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

  logic                    busy;
  logic                    done;
  logic [CntBits-1:0]      count;
  logic [DIVISOR_BITS-1:0] divisor_r;
  logic [DIVISOR_BITS:0]   partial;
  logic [DIVISOR_BITS:0]   diff;
  logic                    ge;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    partial = {remainder, quotient[DIVIDEND_BITS-1]};
    diff    = partial - {1'b0, divisor_r};
    ge      = ~diff[DIVISOR_BITS];
  end

  // Control: load on start, count down one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CntBits'(DIVIDEND_BITS - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - CntBits'(1);
        end
      end
    end
  end

  // Datapath: dividend shifts out as the quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      divisor_r <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIVIDEND_BITS-2:0], ge};
      remainder <= ge ? diff[DIVISOR_BITS-1:0] : partial[DIVISOR_BITS-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

[rtl/core/animation_frame_sequencer.sv]
// Animation frame sequencer top level: config registers, playback clock,
// sequencer and one shared multiplier; depends on afs_pkg and afs_divider.
//
//  channel | signals                                    | flow
//  --------+--------------------------------------------+-------------------
//  input   | in_valid, in_stall, elapsed_ms             | tick in, valid/stall
//  output  | out_valid, out_stall, frame_index,         | result out,
//          | frame_valid, has_played, play_position     | valid/stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | register write
//
// A tick runs up to four passes of the shared divider (key time, backward wrap,
// clock wrap, frame), each framed by sequencer states; with a zero frame count or
// pass length the clock wrap and frame passes are skipped. Reset (synchronous, rst
// high) clears the clock and the played flag and returns the registers to their
// reset values; a stalled result holds and blocks the next load.
`timescale 1ns / 1ps
`default_nettype none

module animation_frame_sequencer #(
  parameter int  FRAME_BITS = 12,
  parameter int  TIME_BITS  = 20,
  localparam int CfgBits    = (TIME_BITS > FRAME_BITS) ? TIME_BITS : FRAME_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [afs_pkg::ElapsedBits-1:0] elapsed_ms,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [FRAME_BITS-1:0]           frame_index,
  output logic                                 frame_valid,
  output logic                                 has_played,
  output logic      [TIME_BITS-1:0]            play_position,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [afs_pkg::CfgIdxBits-1:0]  cfg_index,
  input  wire logic [CfgBits-1:0]              cfg_data
);
  import afs_pkg::*;

  localparam int TW  = TIME_BITS + 1;                        // clock width
  localparam int SW  = ((TW > ElapsedBits) ? TW : ElapsedBits) + 1;
  localparam int PW  = TIME_BITS + FRAME_BITS;               // product width
  localparam int DW  = TIME_BITS + FRAME_BITS + 1;           // dividend width
  localparam int DVW = CfgBits;                              // divisor width

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY_MUL,
    S_KEY_DIV,
    S_KEY_WAIT,
    S_ADVANCE,
    S_BACK_WAIT,
    S_WRAP,
    S_WRAP_WAIT,
    S_FRAME_MUL,
    S_FRAME_DIV,
    S_FRAME_WAIT,
    S_OUTPUT
  } state_t;

  // Configuration registers
  logic [TIME_BITS-1:0]  total_duration;
  logic [FRAME_BITS-1:0] frame_count;
  logic [FRAME_BITS-1:0] loop_keyframe;
  logic                  play_backwards;
  logic                  play_once;
  logic                  hold_paused;

  // Architectural state
  logic [TW-1:0] play_time;
  logic          done_flag;

  // Working registers of the sequencer
  state_t                state;
  logic [TW-1:0]         t;
  logic [ElapsedBits-1:0] e;
  logic [TIME_BITS-1:0]  keytime;
  logic                  done_w;
  logic [FRAME_BITS-1:0] frame_w;
  logic                  wrap_keyed;
  logic                  wrap_fwd;
  logic [PW-1:0]         prod;

  // Divider interface
  logic                  div_start;
  logic [DW-1:0]         div_a;
  logic [DVW-1:0]        div_b;
  logic [DW-1:0]         div_q;
  logic [DVW-1:0]        div_r;
  afs_div_stat_t         div_stat;

  // Decoded configuration
  logic                  bad_key;
  logic                  has_key;
  logic                  run_wrap;
  logic [TIME_BITS-1:0]  span;
  logic [FRAME_BITS-1:0] count_m1;

  // Advance logic
  logic [SW-1:0]         sum;
  logic [TW-1:0]         t_sat;
  logic [TW-1:0]         adv_t;
  logic                  adv_done;
  logic                  adv_mod;
  logic [TW-1:0]         rem_t;
  logic [TIME_BITS-1:0]  key_minus_r;

  // Shared multiplier operands
  logic [TIME_BITS-1:0]  mul_a;
  logic [FRAME_BITS-1:0] mul_b;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      total_duration <= TIME_BITS'(TotalReset);
      frame_count    <= '0;
      loop_keyframe  <= '0;
      play_backwards <= 1'b0;
      play_once      <= 1'b0;
      hold_paused    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (afs_cfg_idx_t'(cfg_index))
        CFG_TOTAL_DURATION: total_duration <= cfg_data[TIME_BITS-1:0];
        CFG_FRAME_COUNT:    frame_count    <= cfg_data[FRAME_BITS-1:0];
        CFG_LOOP_KEYFRAME:  loop_keyframe  <= cfg_data[FRAME_BITS-1:0];
        CFG_PLAY_BACKWARDS: play_backwards <= cfg_data[0];
        CFG_PLAY_ONCE:      play_once      <= cfg_data[0];
        CFG_HOLD_PAUSED:    hold_paused    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decode the keyframe and the wrap conditions
  always_comb begin
    bad_key  = (loop_keyframe != '0) && (loop_keyframe >= frame_count);
    has_key  = (loop_keyframe != '0) && !bad_key;
    run_wrap = (frame_count != '0) && (total_duration != '0);
    span     = total_duration - keytime;
    count_m1 = frame_count - FRAME_BITS'(1);
  end

  // Advance the playback clock by one tick
  always_comb begin
    sum      = SW'(t) + SW'(e);
    t_sat    = (sum > SW'({TW{1'b1}})) ? {TW{1'b1}} : sum[TW-1:0];
    adv_t    = t;
    adv_done = done_w;
    adv_mod  = 1'b0;
    if (!hold_paused) begin
      if (play_backwards) begin
        priority if (has_key && (t >= TW'(keytime))) begin
          adv_t = t_sat;
          if (t_sat >= TW'(total_duration)) begin
            adv_t    = (keytime != '0) ? (TW'(keytime) - TW'(1)) : '0;
            adv_done = 1'b0;
          end
        end else if (SW'(t) > SW'(e)) begin
          adv_t = t - TW'(e);
        end else if (play_once || (total_duration == '0)) begin
          adv_t = '0;
        end else begin
          adv_mod = 1'b1;
        end
      end else begin
        adv_t = t_sat;
        if (t_sat >= TW'(total_duration)) begin
          if (play_once) begin
            adv_t = (total_duration != '0) ? (TW'(total_duration) - TW'(1)) : '0;
          end
          adv_done = 1'b1;
        end
      end
    end
  end

  // Wrap results from the divider remainder
  always_comb begin
    rem_t       = TW'(div_r[TIME_BITS-1:0]);
    key_minus_r = keytime - div_r[TIME_BITS-1:0];
  end

  // Shared multiplier operand select
  always_comb begin
    if (state == S_FRAME_MUL) begin
      mul_a = t[TIME_BITS-1:0];
      mul_b = frame_count;
    end else begin
      mul_a = total_duration;
      mul_b = loop_keyframe;
    end
  end

  // Registered product
  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  // Sequencer: one tick through key time, advance, wrap and frame
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      play_time <= '0;
      done_flag <= 1'b0;
    end else begin
      // Drop the result after its transfer unless a new one loads now
      if (out_valid && !out_stall && (state != S_OUTPUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            e      <= elapsed_ms;
            t      <= play_time;
            done_w <= done_flag;
            state  <= S_KEY_MUL;
          end
        end
        S_KEY_MUL: begin
          keytime <= '0;
          state   <= has_key ? S_KEY_DIV : S_ADVANCE;
        end
        S_KEY_DIV: begin
          div_a     <= DW'(prod);
          div_b     <= DVW'(frame_count);
          div_start <= 1'b1;
          state     <= S_KEY_WAIT;
        end
        S_KEY_WAIT: begin
          div_start <= 1'b0;
          if (div_stat.done) begin
            keytime <= div_q[TIME_BITS-1:0];
            state   <= S_ADVANCE;
          end
        end
        S_ADVANCE: begin
          done_w <= adv_done;
          if (adv_mod) begin
            div_a     <= DW'(e) - DW'(t);
            div_b     <= DVW'(total_duration);
            div_start <= 1'b1;
            state     <= S_BACK_WAIT;
          end else begin
            t     <= adv_t;
            state <= S_WRAP;
          end
        end
        S_BACK_WAIT: begin
          div_start <= 1'b0;
          if (div_stat.done) begin
            t     <= TW'(total_duration) - rem_t;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          frame_w <= '0;
          if (!run_wrap) begin
            state <= S_OUTPUT;
          end else begin
            wrap_keyed <= done_w && has_key;
            wrap_fwd   <= t >= TW'(keytime);
            div_start  <= 1'b1;
            state      <= S_WRAP_WAIT;
            if (done_w && has_key) begin
              div_b <= DVW'(span);
              div_a <= (t >= TW'(keytime)) ? DW'(t - TW'(keytime)) : DW'(TW'(keytime) - t);
            end else begin
              div_b <= DVW'(total_duration);
              div_a <= DW'(t);
            end
          end
        end
        S_WRAP_WAIT: begin
          div_start <= 1'b0;
          if (div_stat.done) begin
            priority if (!wrap_keyed) begin
              t <= rem_t;
            end else if (wrap_fwd) begin
              t <= rem_t + TW'(keytime);
            end else begin
              t <= (div_r[TIME_BITS-1:0] > keytime) ? '0 : TW'(key_minus_r);
            end
            state <= S_FRAME_MUL;
          end
        end
        S_FRAME_MUL: begin
          state <= S_FRAME_DIV;
        end
        S_FRAME_DIV: begin
          div_a     <= DW'(prod);
          div_b     <= DVW'(total_duration);
          div_start <= 1'b1;
          state     <= S_FRAME_WAIT;
        end
        S_FRAME_WAIT: begin
          div_start <= 1'b0;
          if (div_stat.done) begin
            priority if (bad_key) begin
              frame_w <= '0;
            end else if (div_q > DW'(count_m1)) begin
              frame_w <= count_m1;
            end else begin
              frame_w <= div_q[FRAME_BITS-1:0];
            end
            state <= S_OUTPUT;
          end
        end
        S_OUTPUT: begin
          // Load the result once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            frame_index   <= frame_w;
            frame_valid   <= (frame_count != '0);
            has_played    <= done_w;
            play_position <= t[TW-1] ? {TIME_BITS{1'b1}} : t[TIME_BITS-1:0];
            play_time     <= t;
            done_flag     <= done_w;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  afs_divider #(
    .DIVIDEND_BITS(DW),
    .DIVISOR_BITS (DVW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .remainder(div_r),
    .stat     (div_stat)
  );

endmodule

`default_nettype wire

[bench/tb_animation_frame_sequencer.sv]
// Self-checking bench for animation_frame_sequencer: predicts every frame result
// from its own playback clock and register copy. Depends on afs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_animation_frame_sequencer;
  import afs_pkg::*;

  localparam int FRAME_BITS  = 12;
  localparam int TIME_BITS   = 20;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [TIME_BITS:0] CLOCK_MAX = '1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  // Indexes past the register list: writes must be ignored
  localparam logic [CfgIdxBits-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxBits-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [FRAME_BITS-1:0] frame_index;
    logic                  frame_valid;
    logic                  has_played;
    logic [TIME_BITS-1:0]  play_position;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ElapsedBits-1:0] elapsed_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FRAME_BITS-1:0] frame_index;
  logic                  frame_valid;
  logic                  has_played;
  logic [TIME_BITS-1:0]  play_position;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [TIME_BITS-1:0]  cfg_data = '0;

  // Predictor copy of registers and playback state
  logic [TIME_BITS-1:0]  cfg_total;
  logic [FRAME_BITS-1:0] cfg_frames;
  logic [FRAME_BITS-1:0] cfg_keyframe;
  logic                  cfg_backwards;
  logic                  cfg_once;
  logic                  cfg_paused;
  logic [TIME_BITS:0]    play_clock;
  logic                  pass_done;

  logic [ElapsedBits-1:0] elapsed_backlog[$];
  frame_result_t          frame_forecast[$];
  int ticks_offered = 0;
  int ticks_taken = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fails = 0;
  int cycle_count = 0;

  animation_frame_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .elapsed_ms   (elapsed_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_index  (frame_index),
    .frame_valid  (frame_valid),
    .has_played   (has_played),
    .play_position(play_position),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the playback clock by one tick and return the frame to show
  function automatic frame_result_t advance_playback(input logic [ElapsedBits-1:0] elapsed);
    longint unsigned total, frames, key, step, key_time, t, span, rem, frame;
    bit bad_key, use_key;
    frame_result_t res;
    step = longint'(elapsed);
    total = longint'(cfg_total);
    frames = longint'(cfg_frames);
    key = longint'(cfg_keyframe);
    bad_key = (key != 0) && (key >= frames);
    use_key = (key != 0) && !bad_key;
    key_time = use_key ? (total * key) / frames : 0;
    t = longint'(play_clock);
    frame = 0;

    if (!cfg_paused) begin
      if (cfg_backwards) begin
        if (use_key && t >= key_time) begin
          // Inside the keyframe loop the clock still runs forward
          t = t + step;
          if (t > CLOCK_MAX) t = CLOCK_MAX;
          if (t >= total) begin
            t = (key_time > 0) ? key_time - 1 : 0;
            pass_done = 1'b0;
          end
        end else if (t > step) begin
          t = t - step;
        end else if (cfg_once || total == 0) begin
          t = 0;
        end else begin
          t = total - ((step - t) % total);
        end
      end else begin
        t = t + step;
        if (t > CLOCK_MAX) t = CLOCK_MAX;
        if (t >= total) begin
          if (cfg_once) t = (total > 0) ? total - 1 : 0;
          pass_done = 1'b1;
        end
      end
    end

    // Wrap into the pass, or into the keyframe loop once a pass is done
    if (frames != 0 && total != 0) begin
      if (pass_done && use_key) begin
        span = total - key_time;
        if (t >= key_time) begin
          t = ((t - key_time) % span) + key_time;
        end else begin
          rem = (key_time - t) % span;
          t = (rem > key_time) ? 0 : key_time - rem;
        end
      end else begin
        t = t % total;
      end
      frame = (t * frames) / total;
      if (frame > frames - 1) frame = frames - 1;
      if (bad_key) frame = 0;
    end

    play_clock = t[TIME_BITS:0];
    res.frame_index = frame[FRAME_BITS-1:0];
    res.frame_valid = (frames != 0);
    res.has_played = pass_done;
    res.play_position = (t > TIME_MAX) ? TIME_MAX : t[TIME_BITS-1:0];
    return res;
  endfunction

  // Offer the next tick once the previous transfer has completed
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || ticks_taken == ticks_offered) begin
      if (elapsed_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        elapsed_ms <= elapsed_backlog.pop_front();
        in_valid <= 1'b1;
        ticks_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Check each result transfer, then predict each tick transfer
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (frame_forecast.size() == 0) begin
          $error("result transfer with no frame expected");
          fails++;
        end else begin
          want = frame_forecast.pop_front();
          if (frame_index !== want.frame_index) begin
            $error("frame_index: expected %0d, got %0d", want.frame_index, frame_index);
            fails++;
          end
          if (frame_valid !== want.frame_valid) begin
            $error("frame_valid: expected %0d, got %0d", want.frame_valid, frame_valid);
            fails++;
          end
          if (has_played !== want.has_played) begin
            $error("has_played: expected %0d, got %0d", want.has_played, has_played);
            fails++;
          end
          if (play_position !== want.play_position) begin
            $error("play_position: expected %0d, got %0d", want.play_position,
                   play_position);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        frame_forecast.push_back(advance_playback(elapsed_ms));
        ticks_taken++;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Hold until every tick is transferred and every frame has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (elapsed_backlog.size() != 0 || ticks_taken != ticks_offered ||
           frame_forecast.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [TIME_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_TOTAL_DURATION: cfg_total = data;
      CFG_FRAME_COUNT:    cfg_frames = data[FRAME_BITS-1:0];
      CFG_LOOP_KEYFRAME:  cfg_keyframe = data[FRAME_BITS-1:0];
      CFG_PLAY_BACKWARDS: cfg_backwards = data[0];
      CFG_PLAY_ONCE:      cfg_once = data[0];
      CFG_HOLD_PAUSED:    cfg_paused = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain, then load a full playback setting; junk lands in unused upper bits
  task automatic set_playback(input int total, input int frames, input int key,
                              input bit back, input bit once, input bit paused);
    logic [TIME_BITS-1:0] junk;
    wait_idle();
    junk = TIME_BITS'($urandom);
    write_reg(CFG_TOTAL_DURATION, TIME_BITS'(total));
    write_reg(CFG_FRAME_COUNT, {junk[19:12], 12'(frames)});
    write_reg(CFG_LOOP_KEYFRAME, {junk[11:4], 12'(key)});
    write_reg(CFG_PLAY_BACKWARDS, {junk[19:1], back});
    write_reg(CFG_PLAY_ONCE, {junk[18:0], once});
    write_reg(CFG_HOLD_PAUSED, {junk[17:0], 1'b0, paused});
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, TIME_BITS'($urandom));
  endtask

  // One random setting followed by ticks sized against the pass length
  task automatic random_phase(input int count);
    int total, frames, key, lim, pick;
    pick = $urandom_range(9);
    case (pick)
      0: total = 1;
      1, 2, 3: total = $urandom_range(200, 2);
      4, 5, 6: total = $urandom_range(5000, 200);
      7: total = 1048575;
      8: total = $urandom_range(1048575, 1);
      default: total = $urandom_range(70000, 5000);
    endcase
    pick = $urandom_range(9);
    case (pick)
      0: frames = 0;
      1: frames = 1;
      2: frames = 4095;
      default: frames = $urandom_range(64, 2);
    endcase
    pick = $urandom_range(9);
    if (pick <= 4) key = 0;
    else if (pick <= 7) key = (frames > 1) ? $urandom_range(frames - 1, 1) : 0;
    else if (pick == 8) key = $urandom_range(4095, frames);
    else key = $urandom_range(4095);
    set_playback(total, frames, key, 1'($urandom_range(1)), $urandom_range(3) == 0,
                 $urandom_range(7) == 0);
    lim = (2 * total > 65535) ? 65535 : 2 * total;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(19);
      if (pick == 0) elapsed_backlog.push_back(0);
      else if (pick == 1) elapsed_backlog.push_back(16'hffff);
      else if (pick <= 3) elapsed_backlog.push_back(ElapsedBits'($urandom_range(65535)));
      else elapsed_backlog.push_back(ElapsedBits'($urandom_range(lim)));
      // Pause the sender once mid-phase until every frame is back
      if (i == count / 2 && $urandom_range(3) == 0) wait_idle();
    end
  endtask

  initial begin
    cfg_total = TIME_BITS'(TotalReset);
    cfg_frames = '0;
    cfg_keyframe = '0;
    cfg_backwards = 1'b0;
    cfg_once = 1'b0;
    cfg_paused = 1'b0;
    play_clock = '0;
    pass_done = 1'b0;
    send_idle_pct = 33;
    recv_stall_pct = 71;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: no frames, clock runs unwrapped
    elapsed_backlog.push_back(0);
    elapsed_backlog.push_back(16'hffff);
    elapsed_backlog.push_back(1);
    // Zero pass length, forward then backward to zero
    set_playback(0, 10, 0, 0, 0, 0);
    elapsed_backlog.push_back(5);
    set_playback(0, 10, 0, 1, 0, 0);
    elapsed_backlog.push_back(3);
    elapsed_backlog.push_back(16'hffff);
    // Keyframe past the frame count
    set_playback(1000, 10, 15, 0, 0, 0);
    elapsed_backlog.push_back(500);
    // Keyframe loop: finish a pass, loop, then reverse through the loop
    set_playback(1000, 10, 5, 0, 0, 0);
    elapsed_backlog.push_back(999);
    elapsed_backlog.push_back(1);
    elapsed_backlog.push_back(700);
    set_playback(1000, 10, 5, 1, 0, 0);
    elapsed_backlog.push_back(100);
    elapsed_backlog.push_back(600);
    elapsed_backlog.push_back(1000);
    // Play once in both directions
    set_playback(1000, 10, 0, 0, 1, 0);
    elapsed_backlog.push_back(2000);
    set_playback(1000, 10, 0, 1, 1, 0);
    elapsed_backlog.push_back(16'hffff);
    // Clock below a moved keyframe after a pass, while paused
    set_playback(1000, 10, 5, 0, 0, 0);
    elapsed_backlog.push_back(1000);
    set_playback(1000, 10, 8, 0, 0, 1);
    elapsed_backlog.push_back(0);
    elapsed_backlog.push_back(123);
    // Register extremes
    set_playback(1048575, 4095, 4094, 0, 0, 0);
    elapsed_backlog.push_back(16'hffff);
    elapsed_backlog.push_back(0);
    set_playback(1, 1, 0, 0, 0, 0);
    elapsed_backlog.push_back(16'hffff);

    // Run the unwrapped clock into saturation
    set_playback(1000, 0, 0, 0, 0, 0);
    for (int i = 0; i < 40; i++)
      elapsed_backlog.push_back(ElapsedBits'($urandom_range(65535, 60000)));

    for (int seg = 0; seg < 3; seg++) begin
      wait_idle();
      send_idle_pct = (seg == 0) ? 33 : (seg == 1) ? 71 : 0;
      recv_stall_pct = (seg == 0) ? 71 : (seg == 1) ? 33 : 0;
      for (int ph = 0; ph < 8; ph++) random_phase($urandom_range(64, 20));
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
